// File: design/hr_pkg.sv
// Package for the haze removal pixel unit: field widths, register indexes,
// reset values and the configuration struct shared by the lanes.
// No dependencies.
`timescale 1ns / 1ps

package hr_pkg;

   localparam int FIELD_W = 13;
   localparam int OUT_W   = 16;
   localparam int NUM_CH  = 3;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_AIRLIGHT_RED   = 3'd0,
      REG_AIRLIGHT_GREEN = 3'd1,
      REG_AIRLIGHT_BLUE  = 3'd2,
      REG_HAZE_STRENGTH  = 3'd3,
      REG_TRANS_FLOOR    = 3'd4
   } hr_reg_type;

   localparam logic [FIELD_W-1:0] AIRLIGHT_RESET = 13'd4096;
   localparam logic [FIELD_W-1:0] STRENGTH_RESET = 13'd3277;
   localparam logic [FIELD_W-1:0] FLOOR_RESET    = 13'd410;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

   // settings common to all lanes
   typedef struct packed {
      logic [FIELD_W-1:0] strength;
      logic [FIELD_W-1:0] floor;
   } hr_cfg_type;

endpackage

// File: design/hr_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Carries a side vector along with each word. No package dependency.
`timescale 1ns / 1ps

module hr_div #(
   parameter int NUM_W  = 26,
   parameter int DEN_W  = 13,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              advance,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic [NUM_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);

   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  work_ff [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [DEN_W-1:0]  rem_src;
      logic [NUM_W-1:0]  work_src;
      logic [DEN_W-1:0]  den_src;
      logic [SIDE_W-1:0] side_src;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              take;
      logic [DEN_W-1:0]  rem_in;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign work_src = num;
         assign den_src  = den;
         assign side_src = side_in;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign work_src = work_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // remainder stays below den, so DEN_W bits hold it
      assign trial  = {rem_src, work_src[NUM_W-1]};
      assign diff   = trial - {1'b0, den_src};
      assign take   = (trial >= {1'b0, den_src});
      assign rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_in;
            work_ff[s] <= {work_src[NUM_W-2:0], take};
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign quo      = work_ff[NUM_W-1];
   assign side_out = side_ff[NUM_W-1];

endmodule

// File: design/hr_lane.sv
// One color channel lane: transmission estimate, floor, scene recovery, clamp.
// Uses hr_pkg and two hr_div instances.
`timescale 1ns / 1ps

module hr_lane #(
   parameter int FRAC_BITS = 12
) (
   clock,
   advance,
   cfg,
   airlight,
   inv_trans,
   pixel,
   y_out,
   clamp_out
);
   import hr_pkg::*;

   localparam int Q1_W = 2 * FIELD_W;
   localparam int T_W  = (FRAC_BITS + 1 > FIELD_W) ? FRAC_BITS + 1 : FIELD_W;
   localparam int N2_W = FIELD_W + FRAC_BITS;
   localparam int S_W  = N2_W + 2;
   localparam int SIDE1_W = 3 * FIELD_W;
   localparam int SIDE2_W = FIELD_W + 1;
   localparam logic [T_W-1:0]  ONE_T = T_W'(1) << FRAC_BITS;
   localparam logic [Q1_W-1:0] ONE_Q = Q1_W'(1) << FRAC_BITS;

   input  logic                       clock;
   input  logic                       advance;
   input  hr_pkg::hr_cfg_type         cfg;
   input  logic [hr_pkg::FIELD_W-1:0] airlight;
   input  logic [hr_pkg::FIELD_W-1:0] inv_trans;
   input  logic [hr_pkg::FIELD_W-1:0] pixel;
   output logic signed [hr_pkg::OUT_W-1:0] y_out;
   output logic                       clamp_out;

   // front stage: product and operand cleanup
   logic [Q1_W-1:0]    prod_ff;
   logic [FIELD_W-1:0] air_ff, fl_ff, pix_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= inv_trans * cfg.strength;
         air_ff  <= (airlight == '0) ? FIELD_W'(1) : airlight;
         fl_ff   <= (cfg.floor == '0) ? FIELD_W'(1) : cfg.floor;
         pix_ff  <= pixel;
      end
   end

   logic [Q1_W-1:0]    q1;
   logic [SIDE1_W-1:0] side1;

   hr_div #(.NUM_W(Q1_W), .DEN_W(FIELD_W), .SIDE_W(SIDE1_W)) u_div_trans (
      .clock    (clock),
      .advance  (advance),
      .num      (prod_ff),
      .den      (air_ff),
      .side_in  ({pix_ff, air_ff, fl_ff}),
      .quo      (q1),
      .side_out (side1)
   );

   logic [FIELD_W-1:0] pix1, air1, fl1;
   assign {pix1, air1, fl1} = side1;

   // transmission = max(floor, ONE - q); ONE - q is negative when q > ONE
   logic [T_W-1:0]     t_raw, t_in, fl_t;
   logic signed [FIELD_W:0] d_in;
   logic [FIELD_W-1:0] mag_in;
   logic [T_W-1:0]     t_ff;
   logic [N2_W-1:0]    num2_ff;
   logic [SIDE2_W-1:0] side2_ff;

   always_comb begin
      fl_t  = T_W'(fl1);
      t_raw = ONE_T - q1[T_W-1:0];
      if (q1 > ONE_Q || t_raw < fl_t) begin
         t_in = fl_t;
      end else begin
         t_in = t_raw;
      end
      d_in   = $signed({1'b0, pix1}) - $signed({1'b0, air1});
      mag_in = d_in[FIELD_W] ? FIELD_W'(-d_in) : d_in[FIELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff     <= t_in;
         num2_ff  <= {mag_in, {FRAC_BITS{1'b0}}};
         side2_ff <= {d_in[FIELD_W], air1};
      end
   end

   logic [N2_W-1:0]    q2;
   logic [SIDE2_W-1:0] side2;

   hr_div #(.NUM_W(N2_W), .DEN_W(T_W), .SIDE_W(SIDE2_W)) u_div_scene (
      .clock    (clock),
      .advance  (advance),
      .num      (num2_ff),
      .den      (t_ff),
      .side_in  (side2_ff),
      .quo      (q2),
      .side_out (side2)
   );

   // signed quotient (toward zero) plus airlight, then saturate
   logic signed [S_W-1:0] qs, sum;
   logic signed [OUT_W-1:0] y_in;
   logic clamp_in;

   always_comb begin
      qs  = $signed({2'b00, q2});
      if (side2[SIDE2_W-1]) begin
         qs = -qs;
      end
      sum = qs + $signed({{(S_W-FIELD_W){1'b0}}, side2[FIELD_W-1:0]});
      if (sum > S_W'(OUT_MAX)) begin
         y_in     = OUT_MAX;
         clamp_in = 1'b1;
      end else if (sum < S_W'(OUT_MIN)) begin
         y_in     = OUT_MIN;
         clamp_in = 1'b1;
      end else begin
         y_in     = sum[OUT_W-1:0];
         clamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y_out     <= y_in;
         clamp_out <= clamp_in;
      end
   end

endmodule

// File: design/hr_merge.sv
// Merge stage: collects the three lane results into one output word and
// ORs the clamp flags. Uses hr_pkg.
`timescale 1ns / 1ps

module hr_merge (
   input  logic                                   clock,
   input  logic                                   advance,
   input  logic signed [hr_pkg::OUT_W-1:0]        y_lane [hr_pkg::NUM_CH],
   input  logic [hr_pkg::NUM_CH-1:0]              clamp_lane,
   output logic [hr_pkg::NUM_CH*hr_pkg::OUT_W-1:0] data_out,
   output logic                                   sat_out
);
   import hr_pkg::*;

   logic [NUM_CH*OUT_W-1:0] data_in;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         data_in[c*OUT_W +: OUT_W] = y_lane[c];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_out <= data_in;
         sat_out  <= |clamp_lane;
      end
   end

endmodule

// File: design/haze_removal_pixel_unit.sv
// Haze removal pixel unit: three color lanes in parallel, one pixel per cycle
// while the output is not stalled; the two bit-per-stage dividers in each lane
// set most of the pipeline depth.
// The whole pipeline stalls only while a result waits and rsp_tready is low.
// Synchronous active-high reset clears the valid chain and loads register
// reset values.
`timescale 1ns / 1ps

module haze_removal_pixel_unit #(
   parameter int FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: inv_transmission[12:0], red_in[25:13], green_in[38:26],
   //            blue_in[51:39], zero [55:52]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // rsp_tdata: red_out[15:0], green_out[31:16], blue_out[47:32]
   // rsp_tuser: saturated[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [hr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hr_pkg::FIELD_W-1:0]     csr_data
);
   import hr_pkg::*;

   localparam int LAT = 2 * FIELD_W + (FIELD_W + FRAC_BITS) + 4;

   logic [FIELD_W-1:0] air_ff [NUM_CH];
   hr_cfg_type         cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            air_ff[c] <= AIRLIGHT_RESET;
         end
         cfg_ff.strength <= STRENGTH_RESET;
         cfg_ff.floor    <= FLOOR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_AIRLIGHT_RED:   air_ff[0]       <= csr_data;
            REG_AIRLIGHT_GREEN: air_ff[1]       <= csr_data;
            REG_AIRLIGHT_BLUE:  air_ff[2]       <= csr_data;
            REG_HAZE_STRENGTH:  cfg_ff.strength <= csr_data;
            REG_TRANS_FLOOR:    cfg_ff.floor    <= csr_data;
            default: ;
         endcase
      end
   end

   logic [LAT-1:0] valid_ff, valid_in;
   logic           advance;

   assign advance    = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[LAT-1];
   assign valid_in   = {valid_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   logic [FIELD_W-1:0]      inv_trans;
   logic [FIELD_W-1:0]      pix [NUM_CH];
   logic signed [OUT_W-1:0] y_lane [NUM_CH];
   logic [NUM_CH-1:0]       clamp_lane;

   assign inv_trans = req_tdata[FIELD_W-1:0];

   for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
      assign pix[c] = req_tdata[(c+1)*FIELD_W +: FIELD_W];

      hr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock     (clock),
         .advance   (advance),
         .cfg       (cfg_ff),
         .airlight  (air_ff[c]),
         .inv_trans (inv_trans),
         .pixel     (pix[c]),
         .y_out     (y_lane[c]),
         .clamp_out (clamp_lane[c])
      );
   end

   hr_merge u_merge (
      .clock      (clock),
      .advance    (advance),
      .y_lane     (y_lane),
      .clamp_lane (clamp_lane),
      .data_out   (rsp_tdata),
      .sat_out    (rsp_tuser[0])
   );

endmodule

// File: tb/sv/tb_top.sv
// Testbench for haze_removal_pixel_unit: directed table then random pixels,
// each result checked against a local haze recovery predictor.
// Depends on hr_pkg and the design top level.
`timescale 1ns / 1ps

module tb_top;
   import hr_pkg::*;

   localparam int FRAC = 12;
   localparam int LATENCY = 2 * 13 + (13 + FRAC) + 4;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        sat;
   } pixel_out_type;

   typedef struct {
      logic [12:0]   tinv, r, g, b;
      logic          has_exp;
      pixel_out_type exp;
   } table_row_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [55:0] req_tdata = '0;
   logic [2:0] csr_index = '0;
   logic [12:0] csr_data = '0;
   wire req_tready, rsp_tvalid, csr_ready;
   wire [47:0] rsp_tdata;
   wire [0:0] rsp_tuser;

   haze_removal_pixel_unit dut (.*);

   logic [12:0] air_r, air_g, air_b, strength, tfloor;
   pixel_out_type recovered_q[$];
   int mismatches = 0;
   bit rx_idle_on = 1, hold_long = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("tb_top: errors");
      $finish;
   end

   function automatic logic [15:0] recover(logic [12:0] tinv, logic [12:0] pix,
                                           logic [12:0] air, ref logic sat);
      longint a, fl, q, t, y;
      a = (air == 0) ? 1 : air;
      fl = (tfloor == 0) ? 1 : tfloor;
      q = (longint'(tinv) * longint'(strength)) / a;
      t = (1 << FRAC) - q;
      if (t < fl) t = fl;
      y = ((longint'(pix) - a) * (1 << FRAC)) / t + a;
      if (y > 32767) begin
         y = 32767; sat = 1;
      end else if (y < -32768) begin
         y = -32768; sat = 1;
      end
      return y[15:0];
   endfunction

   function automatic pixel_out_type predict_pixel(logic [12:0] tinv, logic [12:0] r,
                                                   logic [12:0] g, logic [12:0] b);
      pixel_out_type p;
      logic s;
      s = 0;
      p.red = recover(tinv, r, air_r, s);
      p.green = recover(tinv, g, air_g, s);
      p.blue = recover(tinv, b, air_b, s);
      p.sat = s;
      return p;
   endfunction

   task automatic write_reg(hr_reg_type idx, logic [12:0] val);
      @(posedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         REG_AIRLIGHT_RED:   air_r = val;
         REG_AIRLIGHT_GREEN: air_g = val;
         REG_AIRLIGHT_BLUE:  air_b = val;
         REG_HAZE_STRENGTH:  strength = val;
         default:            tfloor = val;
      endcase
   endtask

   task automatic write_all(logic [12:0] ar, logic [12:0] ag, logic [12:0] ab,
                            logic [12:0] st, logic [12:0] fl);
      write_reg(REG_AIRLIGHT_RED, ar);
      write_reg(REG_AIRLIGHT_GREEN, ag);
      write_reg(REG_AIRLIGHT_BLUE, ab);
      write_reg(REG_HAZE_STRENGTH, st);
      write_reg(REG_TRANS_FLOOR, fl);
   endtask

   // one word on the request side; the queue is loaded at acceptance
   // tvalid stays high between back-to-back words, drops only for idling
   task automatic send_pixel(logic [12:0] tinv, logic [12:0] r, logic [12:0] g,
                             logic [12:0] b, bit idle_on, bit has_exp,
                             pixel_out_type exp);
      pixel_out_type p;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      p = predict_pixel(tinv, r, g, b);
      if (has_exp && p != exp) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row: expected %h predictor %h", exp, p);
      end
      req_tvalid <= 1;
      req_tdata <= {4'b0, b, g, r, tinv};
      do @(posedge clock); while (!req_tready);
      recovered_q.push_back(p);
   endtask

   task automatic drain;
      int n;
      n = 0;
      req_tvalid <= 0;
      while (recovered_q.size() != 0 && n < 200000) begin
         @(posedge clock); n++;
      end
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // result side: random stalls, or a long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_long = 0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 10) - 1) @(posedge clock);
         end else
            rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixel_out_type got, want;
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser[0]};
         if (recovered_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = recovered_q.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected r %h g %h b %h s %b, ",
                           want.red, want.green, want.blue, want.sat,
                           "got r %h g %h b %h s %b",
                           got.red, got.green, got.blue, got.sat);
            end
         end
      end
   end

   function automatic logic [12:0] rnd_field();
      case ($urandom_range(0, 9))
         0: return 13'd0;
         1: return 13'd4096;
         2: return 13'h1FFF;
         3: return 13'($urandom_range(4097, 8191));
         default: return 13'($urandom_range(0, 4096));
      endcase
   endfunction

   table_row_type rows[$];
   initial begin
      pixel_out_type none;
      none = '0;
      air_r = AIRLIGHT_RESET; air_g = AIRLIGHT_RESET; air_b = AIRLIGHT_RESET;
      strength = STRENGTH_RESET; tfloor = FLOOR_RESET;
      repeat (7) @(posedge clock);
      reset <= 0;
      // after reset: pixel equal to airlight passes through
      rows.push_back('{13'd0, 13'd4096, 13'd4096, 13'd4096, 1,
                       '{16'd4096, 16'd4096, 16'd4096, 1'b0}});
      // zero tinv, t = 1.0: identity
      rows.push_back('{13'd0, 13'd0, 13'd1000, 13'd4096, 1,
                       '{16'd0, 16'd1000, 16'd4096, 1'b0}});
      rows.push_back('{13'd4096, 13'd0, 13'd0, 13'd0, 0, none});
      rows.push_back('{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 0, none});
      rows.push_back('{13'h1FFF, 13'd0, 13'h1FFF, 13'd2048, 0, none});
      rows.push_back('{13'd2048, 13'd1, 13'd4095, 13'd3000, 0, none});
      foreach (rows[i])
         send_pixel(rows[i].tinv, rows[i].r, rows[i].g, rows[i].b, 0,
                    rows[i].has_exp, rows[i].exp);
      drain();
      // zero airlight and zero floor act as one LSB; big strength
      write_all(13'd0, 13'd1, 13'h1FFF, 13'h1FFF, 13'd0);
      for (int i = 0; i < 8; i++)
         send_pixel(rnd_field(), rnd_field(), rnd_field(), rnd_field(), 0, 0, none);
      send_pixel(13'h1FFF, 13'h1FFF, 13'd0, 13'h1FFF, 0, 0, none);
      drain();
      // index beyond the map is ignored by the block
      @(posedge clock);
      csr_valid <= 1; csr_index <= 3'd7; csr_data <= 13'd5;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      write_all(13'd4096, 13'd2000, 13'd1, 13'd0, 13'd4096);
      for (int i = 0; i < 6; i++)
         send_pixel(rnd_field(), rnd_field(), rnd_field(), rnd_field(), 0, 0, none);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         write_all(rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field());
         if (ph == 2) hold_long = 1;
         if (ph == 5) rx_idle_on = 0;
         for (int i = 0; i < 80; i++)
            send_pixel(rnd_field(), rnd_field(), rnd_field(), rnd_field(),
                       ph != 5 && ph != 2, 0, none);
         drain();
      end
      if (mismatches == 0 && recovered_q.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule
